// ----- rtl/core/url_percent_decoder_top_defines.svh -----
// Assertion macros shared by the decoder RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/upd_pkg.sv -----
package upd_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int CNT_W     = 13;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int MAX_BEATS = 3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [CNT_W-1:0] BOUND_MAX = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_PCT   = 2'd1,
        MODE_DIGIT = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             run_last;
        logic             string_done;
        logic             overflow_error;
        logic [CNT_W-1:0] decoded_count;
    } res_t;

    typedef struct packed {
        logic [1:0]           n;
        res_t [MAX_BEATS-1:0] beat;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.val = ch[3:0];
        end
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            h.val = 4'(ch[2:0] + 3'd1) + 4'd8;
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/core/url_percent_decoder_top.sv -----
// URL percent-escape decoder. One string byte enters per s_ beat (tlast marks the
// string's final byte); each byte yields zero to three m_ result beats, which leave
// through a four-entry result queue one per cycle while m_tready is high.
// Throughput is one input byte per cycle while each byte yields at most one
// result and m_tready stays high; a malformed escape that yields two or three
// results holds s_tready low while the queue drains, since a byte is taken only
// when the queue holds at most one beat. out_capacity (APB address 0, reset 4096)
// bounds the decoded bytes per string; the bound is min(out_capacity, 4096).
module url_percent_decoder_top
    import upd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [7:0] in_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // m_tdata: [7:0] out_byte, [20:8] decoded_count, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // m_tuser: [0] byte_valid, [1] run_last, [2] overflow_error
    output logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] cap_reg;
    logic             accept;
    logic             room;
    push_t            push;
    res_t             head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    upd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .capacity (cap_reg),
        .push     (push)
    );

    upd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (m_tvalid),
        .ready (m_tready),
        .head  (head)
    );

    assign m_tdata = {3'b000, head.decoded_count, head.out_byte};
    assign m_tlast = head.string_done;
    assign m_tuser = {head.overflow_error, head.run_last, head.byte_valid};

endmodule

// ----- rtl/core/upd_decode.sv -----
`include "url_percent_decoder_top_defines.svh"

module upd_decode
    import upd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic [CNT_W-1:0] capacity,
    output push_t            push
);

    mode_t            mode_reg, mode_next;
    logic [3:0]       fdv_reg, fdv_next;
    logic [7:0]       fdc_reg, fdc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    hex_t             hx;
    logic [7:0]       pbyte [MAX_BEATS];
    logic [1:0]       pn;
    logic [CNT_W-1:0] bound, room, count_new;
    logic [1:0]       emit, nres;
    logic             ovf_new;

    assign hx = hex_decode(in_byte);

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        fdv_next  = fdv_reg;
        fdc_next  = fdc_reg;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_PCT:
                begin
                    if (hx.ok)
                    begin
                        mode_next = MODE_DIGIT;
                        fdv_next  = hx.val;
                        fdc_next  = in_byte;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_DIGIT: mode_next = MODE_PLAIN;
                default:    mode_next = (in_byte == CH_PERCENT) ? MODE_PCT : MODE_PLAIN;
            endcase
            if (in_last)
            begin
                mode_next = MODE_PLAIN;
                fdv_next  = 4'd0;
                fdc_next  = 8'd0;
            end
        end
    end

    // bytes this beat would emit before the capacity check
    always_comb
    begin
        pbyte[0] = 8'd0;
        pbyte[1] = 8'd0;
        pbyte[2] = 8'd0;
        pn       = 2'd0;
        unique case (mode_reg)
            MODE_PCT:
            begin
                if (!hx.ok)
                begin
                    pbyte[0] = CH_PERCENT;
                    pbyte[1] = in_byte;
                    pn       = 2'd2;
                end
            end
            MODE_DIGIT:
            begin
                if (hx.ok)
                begin
                    pbyte[0] = {fdv_reg, hx.val};
                    pn       = 2'd1;
                end
                else
                begin
                    pbyte[0] = CH_PERCENT;
                    pbyte[1] = fdc_reg;
                    pbyte[2] = in_byte;
                    pn       = 2'd3;
                end
            end
            default:
            begin
                if (in_byte == CH_PLUS)
                begin
                    pbyte[0] = CH_SPACE;
                    pn       = 2'd1;
                end
                else if (in_byte != CH_PERCENT)
                begin
                    pbyte[0] = in_byte;
                    pn       = 2'd1;
                end
            end
        endcase
    end

    // capacity accounting; count may sit above a lowered bound mid-string
    always_comb
    begin
        bound = (capacity > BOUND_MAX) ? BOUND_MAX : capacity;
        room  = (count_reg >= bound) ? '0 : bound - count_reg;
        if (ovf_reg)
        begin
            emit    = 2'd0;
            ovf_new = 1'b1;
        end
        else if (CNT_W'(pn) <= room)
        begin
            emit    = pn;
            ovf_new = 1'b0;
        end
        else
        begin
            emit    = room[1:0];
            ovf_new = 1'b1;
        end
        count_new = count_reg + CNT_W'(emit);
        nres      = (emit == 2'd0 && in_last) ? 2'd1 : emit;
    end

    always_comb
    begin
        push.n = accept ? nres : 2'd0;
        for (int k = 0; k < MAX_BEATS; k++)
        begin
            logic is_end;
            is_end = (2'(k) == nres - 2'd1);
            push.beat[k].out_byte       = (2'(k) < emit) ? pbyte[k] : 8'd0;
            push.beat[k].byte_valid     = (2'(k) < emit);
            push.beat[k].run_last       = is_end;
            push.beat[k].string_done    = is_end && in_last;
            push.beat[k].overflow_error = is_end && in_last && ovf_new;
            push.beat[k].decoded_count  = (is_end && in_last) ? count_new : '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            count_next = in_last ? '0 : count_new;
            ovf_next   = in_last ? 1'b0 : ovf_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            fdv_reg   <= 4'd0;
            fdc_reg   <= 8'd0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            fdv_reg   <= fdv_next;
            fdc_reg   <= fdc_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    `ASSERT_NEXT(a_end_clears, accept && in_last, count_reg == '0 && !ovf_reg && mode_reg == MODE_PLAIN, "string end did not clear decoder state")
    `ASSERT_IMPLIES(a_ovf_no_data, accept && ovf_reg, !push.beat[0].byte_valid, "data emitted after overflow")

endmodule

// ----- rtl/core/upd_outq.sv -----
`include "url_percent_decoder_top_defines.svh"

module upd_outq
    import upd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  valid,
    input  logic  ready,
    output res_t  head
);

    res_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               pop;

    // one input beat can add up to three result beats
    assign room  = (count_reg <= Q_CNT_W'(Q_DEPTH - MAX_BEATS));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];
    assign pop   = valid && ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BEATS; k++)
        begin
            if (2'(k) < push.n)
            begin
                mem_reg[wr_ptr_reg + Q_PTR_W'(k)] <= push.beat[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_q_bound, count_reg <= Q_CNT_W'(Q_DEPTH), "result queue overfilled")
    `ASSERT_IMPLIES(a_q_fit, push.n != 2'd0, count_reg + Q_CNT_W'(push.n) <= Q_CNT_W'(Q_DEPTH), "push does not fit queue")
    `ASSERT_IMPLIES(a_q_ptrs, count_reg == '0 || count_reg == Q_CNT_W'(Q_DEPTH), wr_ptr_reg == rd_ptr_reg, "queue pointers out of step with count")

endmodule

// ----- sim/url_percent_decoder_top_tb.sv -----
module url_percent_decoder_top_tb;
    import upd_pkg::*;

    class upd_scoreboard;
        res_t             expect_q[$];
        int               errors;
        logic [CNT_W-1:0] capacity;
        mode_t            mode;
        logic [3:0]       dig_val;
        logic [7:0]       dig_char;
        int               count;
        bit               ovf;

        function new();
            errors   = 0;
            capacity = CAP_RESET;
            clear_string();
        endfunction

        function void clear_string();
            mode     = MODE_PLAIN;
            dig_val  = 4'd0;
            dig_char = 8'd0;
            count    = 0;
            ovf      = 1'b0;
        endfunction

        function void set_capacity(logic [31:0] value);
            capacity = value[CNT_W-1:0];
        endfunction

        function int nibble_of(logic [7:0] ch);
            if (ch >= "0" && ch <= "9")
                return ch - "0";
            if (ch >= "a" && ch <= "f")
                return ch - "a" + 10;
            if (ch >= "A" && ch <= "F")
                return ch - "A" + 10;
            return -1;
        endfunction

        // works out the beats one accepted string byte gives
        function void note_input(logic [7:0] c, logic last);
            logic [7:0] dec[3];
            res_t       beats[3];
            res_t       r;
            int         dn;
            int         nb;
            int         hv;
            int         bound;
            dn    = 0;
            nb    = 0;
            hv    = nibble_of(c);
            bound = (capacity < BOUND_MAX) ? capacity : BOUND_MAX;
            case (mode)
                MODE_PCT:
                begin
                    if (hv >= 0)
                    begin
                        dig_val  = hv[3:0];
                        dig_char = c;
                        mode     = MODE_DIGIT;
                    end
                    else
                    begin
                        dec[0] = CH_PERCENT;
                        dec[1] = c;
                        dn     = 2;
                        mode   = MODE_PLAIN;
                    end
                end
                MODE_DIGIT:
                begin
                    if (hv >= 0)
                    begin
                        dec[0] = {dig_val, hv[3:0]};
                        dn     = 1;
                    end
                    else
                    begin
                        dec[0] = CH_PERCENT;
                        dec[1] = dig_char;
                        dec[2] = c;
                        dn     = 3;
                    end
                    mode = MODE_PLAIN;
                end
                default:
                begin
                    mode = MODE_PLAIN;
                    if (c == CH_PERCENT)
                        mode = MODE_PCT;
                    else if (c == CH_PLUS)
                    begin
                        dec[0] = CH_SPACE;
                        dn     = 1;
                    end
                    else
                    begin
                        dec[0] = c;
                        dn     = 1;
                    end
                end
            endcase

            for (int i = 0; i < dn; i++)
            begin
                if (ovf)
                    break;
                if (count + 1 > bound)
                begin
                    ovf = 1'b1;
                    break;
                end
                count++;
                r            = '0;
                r.out_byte   = dec[i];
                r.byte_valid = 1'b1;
                beats[nb]    = r;
                nb++;
            end

            if (last)
            begin
                if (nb == 0)
                begin
                    beats[0] = '0;
                    nb       = 1;
                end
                beats[nb-1].string_done    = 1'b1;
                beats[nb-1].overflow_error = ovf;
                beats[nb-1].decoded_count  = count[CNT_W-1:0];
                clear_string();
            end

            if (nb > 0)
                beats[nb-1].run_last = 1'b1;
            for (int i = 0; i < nb; i++)
                expect_q.insert(expect_q.size(), beats[i]);
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (expect_q.size() == 0)
            begin
                $error("unexpected result beat: out_byte %0h", got.out_byte);
                errors++;
                return;
            end
            exp = expect_q.pop_front();
            if (got.out_byte !== exp.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== exp.byte_valid)
            begin
                $error("byte_valid: expected %0b, got %0b", exp.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.run_last !== exp.run_last)
            begin
                $error("run_last: expected %0b, got %0b", exp.run_last, got.run_last);
                errors++;
            end
            if (got.string_done !== exp.string_done)
            begin
                $error("string_done: expected %0b, got %0b", exp.string_done, got.string_done);
                errors++;
            end
            if (got.overflow_error !== exp.overflow_error)
            begin
                $error("overflow_error: expected %0b, got %0b",
                       exp.overflow_error, got.overflow_error);
                errors++;
            end
            if (got.decoded_count !== exp.decoded_count)
            begin
                $error("decoded_count: expected %0d, got %0d",
                       exp.decoded_count, got.decoded_count);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    upd_scoreboard sb = new();
    logic [7:0]    str_q[$];
    int            bytes_sent = 0;
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;
    bit            hold_req = 1'b0;

    url_percent_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // receive side: random back-pressure, plus one long hold-off on request
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (200) @(negedge clk);
        end
        else
            m_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got                = '0;
            got.out_byte       = m_tdata[7:0];
            got.decoded_count  = m_tdata[20:8];
            got.string_done    = m_tlast;
            got.byte_valid     = m_tuser[0];
            got.run_last       = m_tuser[1];
            got.overflow_error = m_tuser[2];
            sb.check_result(got);
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!tx_steady && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_str();
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.expect_q.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        // a suppressed byte leaves nothing to wait on, so allow the pipe to settle
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((addr >> 2) == 0)
            sb.set_capacity(data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic void add_char(input logic [7:0] ch);
        str_q.insert(str_q.size(), ch);
    endfunction

    // mostly well-formed content, some broken escapes; truncation may cut an escape
    function automatic void build_string(input int len);
        int r;
        str_q.delete();
        while (str_q.size() < len)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                add_char(CH_PERCENT);
                add_char(rand_hex_char());
                add_char(rand_hex_char());
            end
            else if (r < 50)
                add_char(CH_PLUS);
            else if (r < 85)
                add_char(8'($urandom_range(255)));
            else
            begin
                add_char(CH_PERCENT);
                if ($urandom_range(1))
                    add_char(rand_hex_char());
                add_char(8'($urandom_range(255)));
            end
        end
        while (str_q.size() > len)
            void'(str_q.pop_back());
    endfunction

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int phase;
        int n_str;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        str_q = '{8'h00, 8'hFF, CH_PLUS, CH_PERCENT, "4", "1", CH_PERCENT, "f", "A",
                  CH_PERCENT, "z", CH_PERCENT, "4", "g", CH_PERCENT, CH_PLUS, 8'h7E};
        send_str();
        str_q = '{CH_PERCENT};         // ends inside an escape with nothing to emit
        send_str();
        str_q = '{CH_PERCENT, "7"};    // incomplete escape dropped
        send_str();
        str_q = '{CH_PLUS};
        send_str();
        drain();

        reg_write(3'd0, 32'd1);
        str_q = '{"a", "b", "c"};
        send_str();
        drain();
        reg_write(3'd0, 32'd0);        // every byte overflows
        str_q = '{"a", CH_PERCENT};
        send_str();
        drain();
        reg_write(3'd0, 32'd3);
        str_q = '{CH_PERCENT, "4", "g", "x"};
        send_str();
        drain();
        reg_write(3'd0, 32'd8191);     // above the hard bound
        reg_write(3'd4, 32'd2);        // unmapped register, no effect
        str_q = '{"q", CH_PERCENT, "2", "B", CH_PERCENT, "5"};
        send_str();
        drain();

        phase = 0;
        while (bytes_sent < 410)
        begin
            case (phase % 5)
                0: reg_write(3'd0, 32'd4096);
                1: reg_write(3'd0, $urandom_range(1, 12));
                2: reg_write(3'd0, $urandom_range(13, 40));
                3: reg_write(3'd0, 32'd1);
                default: reg_write(3'd0, $urandom_range(1, 4096));
            endcase
            tx_steady = (phase == 0);
            rx_steady = (phase == 0);
            if (phase == 2)
                hold_req = 1'b1;
            n_str = (phase == 2) ? 10 : $urandom_range(4, 8);
            repeat (n_str)
            begin
                build_string(($urandom_range(9) == 0) ? 60 : $urandom_range(1, 20));
                send_str();
            end
            drain();
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        drain();
        repeat (16) @(negedge clk);
        if (sb.expect_q.size() != 0)
        begin
            $error("%0d result beats never arrived", sb.expect_q.size());
            sb.errors += sb.expect_q.size();
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
